FILE: hdl/psbrl_pkg.sv
// shared types and constants of the per-source burst rate limiter
package psbrl_pkg;

   localparam int CSR_DATA_W  = 48;
   localparam int CSR_INDEX_W = 2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BURST_LIMIT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAN_LENGTH    = 2'd2;

   typedef struct packed {
      logic [31:0] source_address;
      logic [63:0] arrival_time;
   } req_type;

   typedef struct packed {
      logic drop;
      logic new_source;
   } rsp_type;

   // one table record
   typedef struct packed {
      logic        valid;
      logic [31:0] tag;
      logic [63:0] window_start;
      logic [63:0] ban_deadline;
      logic [16:0] burst_count;
   } record_type;

endpackage

FILE: hdl/psbrl_ram.sv
// generic single-write, single-read synchronous ram with registered read data
module psbrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/psbrl_slot_hash.sv
// slot index unit: folds the source address and reduces it modulo the table depth
module psbrl_slot_hash #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [31:0]                    source_address,
   output logic                           done,
   output logic [$clog2(TABLE_DEPTH)-1:0] slot
);

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

   logic [31:0] folded;

   assign folded = source_address ^ {16'd0, source_address[31:16]};

   generate
      if (IS_POW2) begin : g_mask
         logic [IDX_W-1:0] slot_ff;
         logic             done_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else if (start) begin
               done_ff <= 1'b1;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               slot_ff <= folded[IDX_W-1:0];
            end
         end

         assign done = done_ff;
         assign slot = slot_ff;
      end else begin : g_reduce
         // reciprocal multiplication: estimated quotient,
         // partial remainder, then one compare and subtract
         localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / TABLE_DEPTH);
         localparam logic [31:0] DIVISOR = 32'(TABLE_DEPTH);

         logic [31:0]      fold_ff;
         logic [31:0]      quot_ff;
         logic [31:0]      part_ff;
         logic [IDX_W-1:0] slot_ff;
         logic [2:0]       phase_ff;
         logic             done_ff;
         logic [63:0]      product;

         assign product = fold_ff * RECIP;

         always_ff @(posedge clock) begin
            if (reset) begin
               phase_ff <= '0;
               done_ff  <= 1'b0;
            end else begin
               phase_ff <= {phase_ff[1:0], start};
               if (start) begin
                  done_ff <= 1'b0;
               end else if (phase_ff[2]) begin
                  done_ff <= 1'b1;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               fold_ff <= folded;
            end
            if (phase_ff[0]) begin
               quot_ff <= product[63:32];
            end
            if (phase_ff[1]) begin
               part_ff <= fold_ff - quot_ff * DIVISOR;
            end
            if (phase_ff[2]) begin
               slot_ff <= (part_ff >= DIVISOR) ? IDX_W'(part_ff - DIVISOR)
                                               : part_ff[IDX_W-1:0];
            end
         end

         assign done = done_ff;
         assign slot = slot_ff;
      end
   endgenerate

endmodule

FILE: hdl/per_source_burst_rate_limiter.sv
// top level of the per-source burst rate limiter with ban
//
// usage
// - a packet (source address, arrival time in ns) is taken on a clock edge with
//   start high and busy low; one pass/drop answer comes back per packet
// - the answer sits on rsp_data for one cycle with rsp_strobe high; the receiver
//   cannot hold it off, each strobe is one transfer
// - the burst limit, window length and ban length registers are written through
//   csr_we, csr_index, csr_wdata while the block is idle; an unknown index is ignored
// - when the burst limit or the window length is zero the answer is pass and comes
//   the cycle after the transfer, and the next packet is taken at once
// - otherwise a packet walks hash, table read, compare and update steps: the
//   strobe rises as the update step ends and busy drops with it, so a new
//   packet is taken only once the last one is answered; when the table depth is
//   not a power of two the modulo unit lengthens the hash step
// - the rate is set by the read-modify-write of the single record ram, one
//   packet at a time, so no two accesses to one entry ever overlap
// - after reset busy stays high while a clearing pass zeroes every record;
//   register writes are still taken during that time
module per_source_burst_rate_limiter #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  psbrl_pkg::req_type                        req_data,
   output logic                                      rsp_strobe,
   output psbrl_pkg::rsp_type                        rsp_data,
   input  logic                                      csr_we,
   input  logic [psbrl_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [psbrl_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   import psbrl_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int REC_W = $bits(record_type);

   // state codes
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HASH  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_EVAL  = 3'd4;
   localparam logic [2:0] S_CALC  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] clr_idx_ff;

   // configuration registers
   logic [15:0] burst_limit_ff;
   logic [47:0] window_length_ff;
   logic [47:0] ban_length_ff;

   // packet held for the whole walk
   req_type    req_ff;
   logic       accept;
   logic       limiter_off;

   // slot index unit
   logic             hash_done;
   logic [IDX_W-1:0] slot;

   // ram ports
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   record_type       wr_rec;
   logic             rd_en;
   record_type       rd_rec;

   // compare stage
   record_type  rec_ff;
   logic        hit_ff;
   logic        ban_ff;
   logic        ge_ff;
   logic [63:0] diff_ff;

   // update stage
   logic        in_window;
   logic [16:0] count_next;
   logic        overflow;
   record_type  upd_rec;
   rsp_type     calc_rsp;

   // answer register
   logic    rsp_strobe_ff, rsp_strobe_in;
   rsp_type rsp_data_ff, rsp_data_in;

   assign busy        = (state_ff != S_IDLE);
   assign accept      = start && !busy;
   assign limiter_off = (burst_limit_ff == 16'd0) || (window_length_ff == 48'd0);

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         burst_limit_ff   <= '0;
         window_length_ff <= '0;
         ban_length_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BURST_LIMIT:   burst_limit_ff   <= csr_wdata[15:0];
            CSR_WINDOW_LENGTH: window_length_ff <= csr_wdata;
            CSR_BAN_LENGTH:    ban_length_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   psbrl_slot_hash #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_slot_hash (
      .clock          (clock),
      .reset          (reset),
      .start          (accept && !limiter_off),
      .source_address (req_data.source_address),
      .done           (hash_done),
      .slot           (slot)
   );

   psbrl_ram #(
      .WIDTH(REC_W),
      .DEPTH(TABLE_DEPTH)
   ) u_record_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rec),
      .rd_en   (rd_en),
      .rd_addr (slot),
      .rd_data (rd_rec)
   );

   assign rd_en = (state_ff == S_READ);

   // compare stage: tag match, active ban, window start against arrival time
   always_ff @(posedge clock) begin
      if (state_ff == S_EVAL) begin
         rec_ff  <= rd_rec;
         hit_ff  <= rd_rec.valid && (rd_rec.tag == req_ff.source_address);
         ban_ff  <= (rd_rec.ban_deadline != 64'd0) &&
                    (rd_rec.ban_deadline > req_ff.arrival_time);
         ge_ff   <= (req_ff.arrival_time >= rd_rec.window_start);
         diff_ff <= req_ff.arrival_time - rd_rec.window_start;
      end
   end

   // update stage: install a new source, count the packet, restart the window or arm the ban
   always_comb begin
      in_window  = ge_ff && (diff_ff <= {16'd0, window_length_ff});
      upd_rec    = rec_ff;
      calc_rsp   = '0;
      if (in_window) begin
         count_next = rec_ff.burst_count + 17'd1;
      end else begin
         count_next           = 17'd1;
         upd_rec.window_start = req_ff.arrival_time;
         upd_rec.ban_deadline = 64'd0;
      end
      upd_rec.burst_count = count_next;
      overflow = (count_next > {1'b0, burst_limit_ff});
      if (!hit_ff) begin
         // unknown source or other tag: install a fresh record
         upd_rec.valid        = 1'b1;
         upd_rec.tag          = req_ff.source_address;
         upd_rec.window_start = req_ff.arrival_time;
         upd_rec.ban_deadline = 64'd0;
         upd_rec.burst_count  = 17'd1;
         calc_rsp.new_source  = 1'b1;
      end else if (ban_ff) begin
         calc_rsp.drop = 1'b1;
      end else if (overflow) begin
         upd_rec.burst_count  = 17'd0;
         upd_rec.window_start = req_ff.arrival_time;
         if (ban_length_ff != 48'd0) begin
            upd_rec.ban_deadline = req_ff.arrival_time + {16'd0, ban_length_ff};
         end
         calc_rsp.drop = 1'b1;
      end
   end

   // ram write: clearing pass, or the updated record unless a ban held the packet
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = slot;
      wr_rec  = upd_rec;
      if (state_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_idx_ff;
         wr_rec  = '0;
      end else if (state_ff == S_CALC) begin
         wr_en = !hit_ff || !ban_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_idx_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               if (limiter_off) begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = '0;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            if (hash_done) begin
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_EVAL;
         S_EVAL: state_in = S_CALC;
         S_CALC: begin
            state_in      = S_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_data_in   = calc_rsp;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_idx_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (state_ff == S_CLEAR) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

FILE: sim/psbrl_checker.sv
// checker for the rate limiter: predicts every answer and compares it with the one observed
module psbrl_checker #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  psbrl_pkg::req_type                req_data,
   input  logic                              rsp_strobe,
   input  psbrl_pkg::rsp_type                rsp_data,
   input  logic                              csr_we,
   input  logic [psbrl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [psbrl_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                mismatch_count,
   output int                                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import psbrl_pkg::*;

   logic [15:0] burst_limit;
   logic [47:0] window_len;
   logic [47:0] ban_ns;
   record_type  source_table [TABLE_DEPTH];
   rsp_type     verdicts_due [$];

   initial mismatch_count = 0;

   // decides pass or drop for one packet and updates the shadow table
   function automatic rsp_type judge_packet(req_type pkt);
      logic [31:0] folded;
      int unsigned slot;
      record_type  rec;
      rsp_type     verdict;
      verdict = '0;
      if (burst_limit == '0 || window_len == '0)
         return verdict;
      folded = pkt.source_address ^ (pkt.source_address >> 16);
      slot   = folded % TABLE_DEPTH;
      rec    = source_table[slot];
      if (!rec.valid || rec.tag != pkt.source_address) begin
         rec.valid        = 1'b1;
         rec.tag          = pkt.source_address;
         rec.window_start = pkt.arrival_time;
         rec.ban_deadline = '0;
         rec.burst_count  = 17'd1;
         source_table[slot] = rec;
         verdict.new_source = 1'b1;
         return verdict;
      end
      if (rec.ban_deadline != '0 && rec.ban_deadline > pkt.arrival_time) begin
         verdict.drop = 1'b1;
         return verdict;
      end
      if (pkt.arrival_time >= rec.window_start &&
          pkt.arrival_time - rec.window_start <= {16'b0, window_len}) begin
         rec.burst_count = rec.burst_count + 17'd1;
      end else begin
         rec.burst_count  = 17'd1;
         rec.window_start = pkt.arrival_time;
         rec.ban_deadline = '0;
      end
      if (rec.burst_count > {1'b0, burst_limit}) begin
         rec.burst_count  = '0;
         rec.window_start = pkt.arrival_time;
         if (ban_ns != '0)
            rec.ban_deadline = pkt.arrival_time + {16'b0, ban_ns};
         verdict.drop = 1'b1;
      end
      source_table[slot] = rec;
      return verdict;
   endfunction

   task automatic flag_error(string what);
      if (mismatch_count < 10)
         $display("%0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         burst_limit = '0;
         window_len  = '0;
         ban_ns      = '0;
         for (int i = 0; i < TABLE_DEPTH; i++)
            source_table[i].valid = 1'b0;
         verdicts_due.delete();
      end else begin
         if (rsp_strobe !== 1'b0) begin
            if (verdicts_due.size() == 0) begin
               flag_error($sformatf("answer with none outstanding: drop=%0b new_source=%0b",
                                    rsp_data.drop, rsp_data.new_source));
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_data.drop !== want.drop || rsp_data.new_source !== want.new_source)
                  flag_error($sformatf(
                     "expected drop=%0b new_source=%0b, got drop=%0b new_source=%0b",
                     want.drop, want.new_source, rsp_data.drop, rsp_data.new_source));
            end
         end
         if (csr_we === 1'b1) begin
            case (csr_index)
               CSR_BURST_LIMIT:   burst_limit = csr_wdata[15:0];
               CSR_WINDOW_LENGTH: window_len  = csr_wdata;
               CSR_BAN_LENGTH:    ban_ns      = csr_wdata;
               default: ;
            endcase
         end
         if (start === 1'b1 && busy === 1'b0)
            verdicts_due.push_back(judge_packet(req_data));
      end
      pending_count = verdicts_due.size();
   end

endmodule

FILE: sim/tb_top.sv
// testbench top: clock, reset, packet and register stimulus, final verdict
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import psbrl_pkg::*;

   // index with no register behind it, writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 125;
   localparam int PHASE_COUNT  = 8;
   localparam int SETTING_COUNT = 7;

   typedef struct {
      logic [15:0] burst;
      logic [47:0] window;
      logic [47:0] ban;
   } limits_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   start      = 1'b0;
   req_type                req_data   = '0;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_BURST_LIMIT;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                   busy;
   logic                   rsp_strobe;
   rsp_type                rsp_data;

   int          mismatch_count;
   int          pending_count;
   int          cycle_count = 0;
   int unsigned idle_pct    = 0;
   limits_type  plan [SETTING_COUNT];
   int unsigned idle_modes [3];
   logic [31:0] source_pool [16];

   per_source_burst_rate_limiter i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   psbrl_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog, covers the clearing pass after reset many times over
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // one packet transfer: optional idle cycles, then start held until busy is low
   // entered and left just after a falling edge
   task automatic push_packet(logic [31:0] addr, logic [63:0] stamp);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start                   <= 1'b1;
      req_data.source_address <= addr;
      req_data.arrival_time   <= stamp;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      @(negedge clock);
   endtask

   // one register write, followed by a quiet cycle so writes never touch in one step
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // hold the sender off until every answer is back, then allow the pipeline to empty
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (pending_count != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic program_limits(limits_type lim);
      write_reg(CSR_BURST_LIMIT, {32'b0, lim.burst});
      write_reg(CSR_WINDOW_LENGTH, lim.window);
      write_reg(CSR_BAN_LENGTH, lim.ban);
   endtask

   // mostly sequences from a small source pool with time stepping around the
   // window and ban lengths, the rest raw random packets
   task automatic run_phase(limits_type lim, int count);
      logic [63:0] now_ns;
      logic [63:0] step;
      logic [63:0] span;
      logic [31:0] addr;
      int unsigned pick;
      int unsigned roll;
      now_ns = {$urandom, $urandom};
      span   = {16'b0, lim.window} >> 2;
      pick   = 0;
      // odd entries share a table slot with their even neighbour
      for (int k = 0; k < 16; k++)
         source_pool[k] = (k % 2 == 1) ?
                          source_pool[k-1] ^ {4'($urandom_range(1, 15)), 28'b0} : $urandom;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2)
            drain();
         if ($urandom_range(0, 99) < 15) begin
            addr = $urandom;
            push_packet(addr, {$urandom, $urandom});
         end else begin
            if ($urandom_range(0, 99) >= 60)
               pick = $urandom_range(0, 15);
            roll = $urandom_range(0, 99);
            if (roll < 58)
               step = {$urandom, $urandom} % (span + 64'd1);
            else if (roll < 74)
               step = {16'b0, lim.window} + 64'($urandom_range(1, 2));
            else if (roll < 80)
               step = {16'b0, lim.window};
            else if (roll < 90)
               step = {16'b0, lim.ban} - 64'($urandom_range(0, 1));
            else if (roll < 96)
               step = 64'd0 - 64'($urandom_range(1, 40));
            else
               step = {$urandom, $urandom};
            now_ns = now_ns + step;
            push_packet(source_pool[pick], now_ns);
         end
      end
   endtask

   initial begin
      logic [31:0] src_a;
      logic [31:0] src_b;
      logic [31:0] src_c;
      logic [31:0] src_d;
      limits_type  lim;
      src_a = 32'h0A00_0001;
      src_b = src_a ^ 32'hF000_0000;   // same slot as src_a
      src_c = 32'hC0A8_0101;
      src_d = 32'h1234_5678;
      plan = '{
         '{16'd3,     48'd100,             48'd50},
         '{16'd1,     48'd1,               48'd0},
         '{16'hFFFF,  48'hFFFF_FFFF_FFFF,  48'hFFFF_FFFF_FFFF},
         '{16'd5,     48'd1000,            48'd300},
         '{16'd2,     48'hFFFF_FFFF_FFFF,  48'd1},
         '{16'd0,     48'd500,             48'd20},
         '{16'd4,     48'd0,               48'd77}
      };
      idle_modes = '{0, 62, 27};

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // limiter off after reset: everything passes
      push_packet(32'h0000_0000, 64'h0);
      push_packet(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      drain();
      // burst limit set but window still zero: still off
      write_reg(CSR_BURST_LIMIT, 48'd2);
      push_packet(src_a, 64'd10);
      drain();
      // spare index must not disturb any register
      write_reg(CSR_SPARE, 48'hFFFF_FFFF_FFFF);
      write_reg(CSR_WINDOW_LENGTH, 48'd100);
      write_reg(CSR_BAN_LENGTH, 48'd50);

      // install, count up, overflow into a ban, ban expiry, time going backwards
      push_packet(src_a, 64'd1000);
      push_packet(src_a, 64'd1050);
      push_packet(src_a, 64'd1100);
      push_packet(src_a, 64'd1149);
      push_packet(src_a, 64'd1150);
      push_packet(src_a, 64'd1000);
      // slot collision evicts the other source
      push_packet(src_b, 64'd1001);
      push_packet(src_a, 64'd1002);
      // one past the window edge opens a new window
      push_packet(src_a, 64'd1103);
      push_packet(32'h0000_0000, 64'h0);
      push_packet(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      // ban deadline wraps to exactly zero, so no ban
      push_packet(src_c, 64'hFFFF_FFFF_FFFF_FFCC);
      push_packet(src_c, 64'hFFFF_FFFF_FFFF_FFCD);
      push_packet(src_c, 64'hFFFF_FFFF_FFFF_FFCE);
      push_packet(src_c, 64'hFFFF_FFFF_FFFF_FFCF);
      // deadline wraps past zero and still bans after the timestamp wraps
      push_packet(src_d, 64'hFFFF_FFFF_FFFF_FFEC);
      push_packet(src_d, 64'hFFFF_FFFF_FFFF_FFED);
      push_packet(src_d, 64'hFFFF_FFFF_FFFF_FFEE);
      push_packet(src_d, 64'd5);
      push_packet(src_d, 64'd32);

      // random phases, each with limits from the plan and a sender idling mode
      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain();
         lim = plan[p % SETTING_COUNT];
         program_limits(lim);
         idle_pct = idle_modes[p % 3];
         run_phase(lim, PHASE_ITEMS);
      end

      drain();
      repeat (16) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/psbrl_pkg.sv
hdl/psbrl_ram.sv
hdl/psbrl_slot_hash.sv
hdl/per_source_burst_rate_limiter.sv
sim/psbrl_checker.sv
sim/tb_top.sv
